@@ src/lbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Login burst detector package
// Shared sizes, codes, record types and index wrap tables.
// ----------------------------------------------------------------------------
package lbd_pkg;

    // Sizes of the per-user and banned-address stores.
    localparam int USER_SLOTS   = 64;
    localparam int HIST_DEPTH   = 4;
    localparam int BAN_SLOTS    = 16;

    // Fixed field widths of one transfer.
    localparam int USER_FW      = 6;
    localparam int SLOT_FW      = 4;
    localparam int ADDR_W       = 32;
    localparam int TIME_W       = 32;
    localparam int WIN_W        = 16;
    localparam int TOTAL_W      = 32;

    localparam int USER_AW      = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int BAN_AW       = (BAN_SLOTS > 1) ? $clog2(BAN_SLOTS) : 1;
    localparam int POS_W        = $clog2(HIST_DEPTH);
    localparam int CNT_W        = $clog2(HIST_DEPTH + 1);

    localparam int USER_CODES   = 2 ** USER_FW;
    localparam int SLOT_CODES   = 2 ** SLOT_FW;

    localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(HIST_DEPTH);
    localparam logic [POS_W-1:0]   POS_LAST = POS_W'(HIST_DEPTH - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(20);

    typedef enum logic [1:0] {
        OP_LOGIN = 2'd0,
        OP_BAN   = 2'd1,
        OP_AUTH  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_BANNED   = 2'd1,
        VERDICT_FREQUENT = 2'd2
    } verdict_t;

    typedef struct packed {
        logic             auth;
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] pos;
    } user_state_t;

    typedef logic [HIST_DEPTH-1:0][TIME_W-1:0] hist_row_t;

    // Write request into the per-user stores.
    typedef struct packed {
        logic               state_en;
        logic               hist_en;
        logic [USER_AW-1:0] user;
        user_state_t        state;
        hist_row_t          row;
    } user_wr_t;

    // Write request into the banned-address table.
    typedef struct packed {
        logic              en;
        logic [BAN_AW-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic              flag;
    } ban_wr_t;

    typedef logic [USER_AW-1:0] user_wrap_tbl_t [USER_CODES];
    typedef logic [BAN_AW-1:0]  slot_wrap_tbl_t [SLOT_CODES];

    function automatic user_wrap_tbl_t build_user_wrap();
        user_wrap_tbl_t t;
        for (int i = 0; i < USER_CODES; i++) begin
            t[i] = USER_AW'(i % USER_SLOTS);
        end
        return t;
    endfunction

    function automatic slot_wrap_tbl_t build_slot_wrap();
        slot_wrap_tbl_t t;
        for (int i = 0; i < SLOT_CODES; i++) begin
            t[i] = BAN_AW'(i % BAN_SLOTS);
        end
        return t;
    endfunction

    // Out-of-range indexes wrap around the store size.
    localparam user_wrap_tbl_t USER_WRAP = build_user_wrap();
    localparam slot_wrap_tbl_t SLOT_WRAP = build_slot_wrap();

endpackage

@@ src/login_burst_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Login burst detector
// Flags logins from banned addresses and unauthorized users with four logins in a window.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle while the output is not stalled; the
// per-user memories are read at the input transfer and written back as it
// leaves the first stage, with forwarding between.
// Reset: totals, valid bits and user state clear at once; window returns to 20.
// ----------------------------------------------------------------------------
module login_burst_detector (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: window in seconds.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: user_index[5:0], source_address[37:6], timestamp_seconds[69:38],
    //        slot_index[73:70], entry_flag[74], zero fill [79:75]
    input  logic [79:0] s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: verdict[1:0], flag_total[33:2], event_total[65:34], zero fill [71:66]
    output logic [71:0] m_tdata
);
    import lbd_pkg::*;

    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    logic [USER_AW-1:0]   s1_user_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [TIME_W-1:0]    s1_stamp_reg;
    logic [BAN_AW-1:0]    s1_slot_reg;
    logic                 s1_flag_reg;

    logic                 out_valid_reg;
    logic [1:0]           out_verdict_reg;

    logic [TOTAL_W-1:0]   flag_cnt_reg, flag_cnt_next;
    logic [TOTAL_W-1:0]   event_cnt_reg, event_cnt_next;
    logic [WIN_W-1:0]     window_reg;

    logic                 advance;
    logic                 accept;
    logic                 fire;
    logic [USER_AW-1:0]   in_user;

    user_state_t          cur_state;
    hist_row_t            cur_row;
    hist_row_t            new_row;
    logic                 banned;
    logic                 is_login;
    logic                 record;
    logic [POS_W-1:0]     new_pos;
    logic [CNT_W-1:0]     new_cnt;
    logic [TIME_W-1:0]    diff;
    logic                 burst;
    verdict_t             verdict;
    user_wr_t             user_wr;
    ban_wr_t              ban_wr;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign fire      = s1_valid_reg && advance;
    assign in_user   = USER_WRAP[s_tdata[5:0]];

    lbd_user_mem u_user_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_user  (in_user),
        .wr       (user_wr),
        .rd_state (cur_state),
        .rd_row   (cur_row)
    );

    lbd_ban_table u_ban_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (ban_wr),
        .lookup_addr (s1_addr_reg),
        .hit         (banned)
    );

    always_comb
    begin
        is_login = (s1_op_reg == OP_LOGIN);
        record   = is_login && !banned;
        new_pos  = (cur_state.pos == POS_LAST) ? '0 : cur_state.pos + 1'b1;
        new_cnt  = (cur_state.cnt < CNT_FULL) ? cur_state.cnt + 1'b1 : cur_state.cnt;

        new_row              = cur_row;
        new_row[cur_state.pos] = s1_stamp_reg;

        // The slot after the write position holds the oldest kept time.
        diff  = s1_stamp_reg - cur_row[new_pos];
        burst = !cur_state.auth && (new_cnt == CNT_FULL)
                && (diff[TIME_W-1] || (diff <= TIME_W'(window_reg)));

        if (is_login && banned)
        begin
            verdict = VERDICT_BANNED;
        end
        else if (record && burst)
        begin
            verdict = VERDICT_FREQUENT;
        end
        else
        begin
            verdict = VERDICT_NONE;
        end

        user_wr.state_en = fire && (record || (s1_op_reg == OP_AUTH));
        user_wr.hist_en  = fire && record;
        user_wr.user     = s1_user_reg;
        user_wr.row      = new_row;
        if (record)
        begin
            user_wr.state = '{auth: cur_state.auth, cnt: new_cnt, pos: new_pos};
        end
        else
        begin
            user_wr.state = '{auth: s1_flag_reg, cnt: cur_state.cnt, pos: cur_state.pos};
        end

        ban_wr.en   = fire && (s1_op_reg == OP_BAN);
        ban_wr.slot = s1_slot_reg;
        ban_wr.addr = s1_addr_reg;
        ban_wr.flag = s1_flag_reg;

        flag_cnt_next  = flag_cnt_reg;
        event_cnt_next = event_cnt_reg;
        if (is_login)
        begin
            if (event_cnt_reg != TOTAL_MAX)
            begin
                event_cnt_next = event_cnt_reg + 1'b1;
            end
            if ((verdict != VERDICT_NONE) && (flag_cnt_reg != TOTAL_MAX))
            begin
                flag_cnt_next = flag_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_cnt_reg  <= '0;
            event_cnt_reg <= '0;
            window_reg    <= WINDOW_RESET;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                flag_cnt_reg  <= flag_cnt_next;
                event_cnt_reg <= event_cnt_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= s_tuser;
            s1_user_reg  <= in_user;
            s1_addr_reg  <= s_tdata[37:6];
            s1_stamp_reg <= s_tdata[69:38];
            s1_slot_reg  <= SLOT_WRAP[s_tdata[73:70]];
            s1_flag_reg  <= s_tdata[74];
        end
        if (fire)
        begin
            out_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, event_cnt_reg, flag_cnt_reg, out_verdict_reg};

    // Flags only ever count login events, so they cannot outrun the event total.
    a_flag_le_event: assert property (@(posedge clk) disable iff (!rst_n)
        flag_cnt_reg <= event_cnt_reg)
        else $error("flag total exceeds event total");

    a_table_write_keeps_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_op_reg != OP_LOGIN)) |=> ($stable(event_cnt_reg) && $stable(flag_cnt_reg)))
        else $error("table write changed the totals");

    a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transfer lost");

endmodule

@@ src/lbd_ban_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banned address table
// Small register table with per-slot valid bits and a parallel match.
// ----------------------------------------------------------------------------
module lbd_ban_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbd_pkg::ban_wr_t      wr,
    input  logic [lbd_pkg::ADDR_W-1:0] lookup_addr,
    output logic                  hit
);
    import lbd_pkg::*;

    logic [ADDR_W-1:0]    addr_reg [BAN_SLOTS];
    logic [BAN_SLOTS-1:0] valid_reg;
    logic [BAN_SLOTS-1:0] match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.slot] <= wr.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            addr_reg[wr.slot] <= wr.addr;
        end
    end

    always_comb
    begin
        for (int s = 0; s < BAN_SLOTS; s++)
        begin
            match[s] = valid_reg[s] && (addr_reg[s] == lookup_addr);
        end
    end

    assign hit = |match;

endmodule

@@ src/lbd_user_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-user store
// State and time history memories with registered reads and write forwarding.
// ----------------------------------------------------------------------------
module lbd_user_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [lbd_pkg::USER_AW-1:0] rd_user,
    input  lbd_pkg::user_wr_t          wr,
    output lbd_pkg::user_state_t       rd_state,
    output lbd_pkg::hist_row_t         rd_row
);
    import lbd_pkg::*;

    user_state_t state_mem [USER_SLOTS];
    hist_row_t   hist_mem  [USER_SLOTS];

    logic [USER_SLOTS-1:0] valid_reg;

    user_state_t state_rd_reg;
    hist_row_t   row_rd_reg;
    logic        state_valid_reg;
    logic        fwd_state_hit_reg;
    logic        fwd_hist_hit_reg;
    user_state_t fwd_state_reg;
    hist_row_t   fwd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr.state_en)
        begin
            state_mem[wr.user] <= wr.state;
        end
        if (rd_en)
        begin
            state_rd_reg <= state_mem[rd_user];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.hist_en)
        begin
            hist_mem[wr.user] <= wr.row;
        end
        if (rd_en)
        begin
            row_rd_reg <= hist_mem[rd_user];
        end
    end

    // A write landing on the same edge as the read is captured for forwarding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            state_valid_reg   <= 1'b0;
            fwd_state_hit_reg <= 1'b0;
            fwd_hist_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr.state_en)
            begin
                valid_reg[wr.user] <= 1'b1;
            end
            if (rd_en)
            begin
                state_valid_reg   <= valid_reg[rd_user];
                fwd_state_hit_reg <= wr.state_en && (wr.user == rd_user);
                fwd_hist_hit_reg  <= wr.hist_en && (wr.user == rd_user);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_state_reg <= wr.state;
            fwd_row_reg   <= wr.row;
        end
    end

    always_comb
    begin
        if (fwd_state_hit_reg)
        begin
            rd_state = fwd_state_reg;
        end
        else if (state_valid_reg)
        begin
            rd_state = state_rd_reg;
        end
        else
        begin
            rd_state = '0;
        end
        rd_row = fwd_hist_hit_reg ? fwd_row_reg : row_rd_reg;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Login burst detector testbench
// Drives login events, banned-table writes, authorized marks and unused
// operations through the input stream under random idling on both sides, and
// compares each result with its directed expectation or a local detector model.
// It starts with a short directed table, then walks several window settings.
// ----------------------------------------------------------------------------
module tb;

    import lbd_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         PHASE_ITEMS = 160;
    localparam int         POOL_SIZE   = 6;
    localparam int         DIRECTED_N  = 24;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  user;
        logic [31:0] addr;
        logic [31:0] stamp;
        logic [3:0]  slot;
        logic        flag;
    } login_req_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] flags;
        logic [31:0] events;
    } login_verdict_t;

    typedef struct packed {
        login_req_t     req;
        logic           typed;
        login_verdict_t want;
    } directed_row_t;

    // Rows with typed = 1 carry their own expectation; the rest use the model.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd0,          4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd0, 32'd1}},
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd5,          4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd0, 32'd2}},
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd10,         4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd0, 32'd3}},
        // Span exactly equal to the window is a burst.
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd20,         4'd0,  1'b0}, 1'b1,
          '{VERDICT_FREQUENT, 32'd1, 32'd4}},
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd26,         4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd1, 32'd5}},
        '{'{OP_BAN,   6'd0,  32'hFFFF_FFFF, 32'd0,          4'd15, 1'b1}, 1'b1,
          '{VERDICT_NONE,     32'd1, 32'd5}},
        '{'{OP_BAN,   6'd0,  32'h0A00_0001, 32'd0,          4'd0,  1'b1}, 1'b1,
          '{VERDICT_NONE,     32'd1, 32'd5}},
        '{'{OP_LOGIN, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  4'd0,  1'b0}, 1'b1,
          '{VERDICT_BANNED,   32'd2, 32'd6}},
        '{'{OP_LOGIN, 6'd1,  32'h0A00_0001, 32'd100,        4'd0,  1'b0}, 1'b1,
          '{VERDICT_BANNED,   32'd3, 32'd7}},
        '{'{OP_BAN,   6'd0,  32'hFFFF_FFFF, 32'd0,          4'd15, 1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd3, 32'd7}},
        '{'{OP_LOGIN, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd3, 32'd8}},
        '{'{OP_AUTH,  6'd0,  32'h0000_0000, 32'd0,          4'd0,  1'b1}, 1'b1,
          '{VERDICT_NONE,     32'd3, 32'd8}},
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd27,         4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd3, 32'd9}},
        '{'{OP_AUTH,  6'd0,  32'h0000_0000, 32'd0,          4'd0,  1'b0}, 1'b1,
          '{VERDICT_NONE,     32'd3, 32'd9}},
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd28,         4'd0,  1'b0}, 1'b1,
          '{VERDICT_FREQUENT, 32'd4, 32'd10}},
        '{'{OP_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1}, 1'b1,
          '{VERDICT_NONE,     32'd4, 32'd10}},
        // Time going backwards gives a negative span, which counts as a burst.
        '{'{OP_LOGIN, 6'd0,  32'h0000_0000, 32'd0,          4'd0,  1'b0}, 1'b1,
          '{VERDICT_FREQUENT, 32'd5, 32'd11}},
        '{'{OP_AUTH,  6'd63, 32'h0000_0000, 32'd0,          4'd0,  1'b1}, 1'b1,
          '{VERDICT_NONE,     32'd5, 32'd11}},
        '{'{OP_LOGIN, 6'd63, 32'h0000_0001, 32'd0,          4'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOGIN, 6'd63, 32'h0000_0001, 32'd3,          4'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOGIN, 6'd63, 32'h0000_0001, 32'd4,          4'd0,  1'b0}, 1'b0, '0},
        '{'{OP_AUTH,  6'd63, 32'h0000_0000, 32'd0,          4'd0,  1'b0}, 1'b0, '0},
        '{'{OP_LOGIN, 6'd63, 32'h0000_0001, 32'd5,          4'd0,  1'b0}, 1'b0, '0},
        '{'{OP_BAN,   6'd0,  32'h0000_0000, 32'd0,          4'd0,  1'b0}, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // tdata: user_index, source_address, timestamp_seconds, slot_index, entry_flag
    logic [79:0] s_tdata;
    // tuser: operation
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // tdata: verdict, flag_total, event_total
    logic [71:0] m_tdata;

    // Local copy of the detector state.
    logic [31:0] stamp_ring [USER_SLOTS][HIST_DEPTH];
    int          attempts   [USER_SLOTS];
    int          ring_pos   [USER_SLOTS];
    logic        auth_mark  [USER_SLOTS];
    logic [31:0] ban_addr   [BAN_SLOTS];
    logic        ban_valid  [BAN_SLOTS];
    logic [31:0] flag_count;
    logic [31:0] event_count;
    logic [15:0] window;

    login_verdict_t verdicts_due [$];

    // Stimulus shaping.
    logic [31:0] last_stamp [USER_SLOTS];
    logic [31:0] ban_pool   [POOL_SIZE];
    int          hot_base;
    int          send_idle_pct;
    int          ready_idle_pct;

    int mismatches;
    int quiet_cycles;
    int login_count;
    int table_writes;
    int unused_ops;
    int banned_seen;
    int burst_seen;

    login_burst_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one request to the local state and returns the result it causes.
    function automatic login_verdict_t judge_request(input login_req_t req);
        login_verdict_t res;
        logic           hit;
        int             u;
        int             nxt;
        logic [31:0]    span;
        res.verdict = VERDICT_NONE;
        hit = 1'b0;
        u = int'(req.user) % USER_SLOTS;
        if (req.op == OP_BAN)
        begin
            ban_addr[int'(req.slot) % BAN_SLOTS] = req.addr;
            ban_valid[int'(req.slot) % BAN_SLOTS] = req.flag;
        end
        else if (req.op == OP_AUTH)
        begin
            auth_mark[u] = req.flag;
        end
        else if (req.op == OP_LOGIN)
        begin
            for (int s = 0; s < BAN_SLOTS; s++)
            begin
                if (ban_valid[s] && ban_addr[s] == req.addr)
                    hit = 1'b1;
            end
            if (hit)
            begin
                res.verdict = VERDICT_BANNED;
            end
            else
            begin
                nxt = (ring_pos[u] + 1) % HIST_DEPTH;
                stamp_ring[u][ring_pos[u]] = req.stamp;
                ring_pos[u] = nxt;
                if (attempts[u] < HIST_DEPTH)
                    attempts[u]++;
                if (!auth_mark[u] && attempts[u] >= HIST_DEPTH)
                begin
                    span = req.stamp - stamp_ring[u][nxt];
                    if (span[31] || span <= {16'd0, window})
                        res.verdict = VERDICT_FREQUENT;
                end
            end
            if (res.verdict != VERDICT_NONE && flag_count != TOTAL_MAX)
                flag_count++;
            if (event_count != TOTAL_MAX)
                event_count++;
        end
        res.flags = flag_count;
        res.events = event_count;
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input login_req_t req, input logic typed,
                                input login_verdict_t want);
        login_verdict_t guess;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {5'd0, req.flag, req.slot, req.stamp, req.addr, req.user};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        guess = judge_request(req);
        verdicts_due.insert(verdicts_due.size(), typed ? want : guess);
        if (req.op == OP_LOGIN)
            login_count++;
        else if (req.op == OP_UNUSED)
            unused_ops++;
        else
            table_writes++;
        @(negedge clk);
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_window(input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        window = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly login bursts from a few users, with table writes and noise mixed in.
    task automatic random_phase(input int count, input logic pause_midway);
        login_req_t req;
        int         r;
        int         u;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                drain_results();
            r = $urandom_range(0, 99);
            u = (hot_base + $urandom_range(0, 5)) % USER_SLOTS;
            req.op    = OP_LOGIN;
            req.user  = 6'($urandom);
            req.addr  = $urandom;
            req.stamp = $urandom;
            req.slot  = 4'($urandom);
            req.flag  = 1'($urandom);
            if (r < 68)
            begin
                req.user = 6'(u);
                if ($urandom_range(0, 99) < 25)
                    req.addr = ban_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 99) < 3)
                    last_stamp[u] = last_stamp[u] - $urandom_range(1, 50);
                else
                    last_stamp[u] = last_stamp[u] + $urandom_range(0, window / 2 + 4);
                req.stamp = last_stamp[u];
            end
            else if (r < 80)
            begin
                req.op = OP_BAN;
                if ($urandom_range(0, 99) < 70)
                    req.addr = ban_pool[$urandom_range(0, POOL_SIZE - 1)];
                req.flag = ($urandom_range(0, 99) < 70);
            end
            else if (r < 88)
            begin
                req.op   = OP_AUTH;
                req.user = 6'(u);
                req.flag = ($urandom_range(0, 99) < 40);
            end
            else if (r < 92)
            begin
                req.op = OP_UNUSED;
            end
            send_request(req, 1'b0, '0);
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        login_verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tdata[1:0] == VERDICT_BANNED)
                banned_seen++;
            if (m_tdata[1:0] == VERDICT_FREQUENT)
                burst_seen++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[1:0] != want.verdict)
                begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, want.verdict, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[33:2] != want.flags)
                begin
                    $display("%0t: flag_total expected %0d actual %0d",
                             $time, want.flags, m_tdata[33:2]);
                    mismatches++;
                end
                if (m_tdata[65:34] != want.events)
                begin
                    $display("%0t: event_total expected %0d actual %0d",
                             $time, want.events, m_tdata[65:34]);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if the block stops moving transfers altogether.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, verdicts_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        directed_row_t  row;
        logic [15:0]    windows [5];
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        send_idle_pct  = 24;
        ready_idle_pct = 24;
        mismatches     = 0;
        quiet_cycles   = 0;
        login_count    = 0;
        table_writes   = 0;
        unused_ops     = 0;
        banned_seen    = 0;
        burst_seen     = 0;
        flag_count     = '0;
        event_count    = '0;
        window         = WINDOW_RESET;
        for (int u = 0; u < USER_SLOTS; u++)
        begin
            attempts[u]   = 0;
            ring_pos[u]   = 0;
            auth_mark[u]  = 1'b0;
            last_stamp[u] = $urandom;
            for (int d = 0; d < HIST_DEPTH; d++)
                stamp_ring[u][d] = '0;
        end
        for (int s = 0; s < BAN_SLOTS; s++)
        begin
            ban_addr[s]  = '0;
            ban_valid[s] = 1'b0;
        end
        for (int p = 0; p < POOL_SIZE; p++)
            ban_pool[p] = $urandom;
        windows[0] = 16'd0;
        windows[1] = 16'hFFFF;
        windows[2] = 16'd25;
        windows[3] = 16'($urandom_range(1, 400));
        windows[4] = 16'd20;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            row = DIRECTED_ROWS[i];
            send_request(row.req, row.typed, row.want);
        end

        for (int p = 0; p < 5; p++)
        begin
            write_window(windows[p]);
            hot_base = $urandom_range(0, USER_SLOTS - 1);
            // One phase runs with neither side idling.
            send_idle_pct  = (p == 2) ? 0 : 24;
            ready_idle_pct = (p == 2) ? 0 : 24;
            random_phase(PHASE_ITEMS, p == 1);
        end

        drain_results();
        repeat (10) @(negedge clk);

        $display("Covered %0d logins (%0d banned, %0d bursts), %0d table writes,",
                 login_count, banned_seen, burst_seen, table_writes);
        $display("%0d unused operations, and windows from 0 to 65535.", unused_ops);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
